// File: hw/rtl/rid_pkg.sv
// ----------------------------------------------------------------------------
// rid_pkg
// Shared types and constants of the ring-ion distance histogram unit.
// ----------------------------------------------------------------------------
package rid_pkg;

  localparam int MAX_RINGS_DEF = 256;
  localparam int MAX_IONS_DEF  = 256;
  localparam int NUM_BINS_DEF  = 128;

  localparam int CW   = 24;  // coordinate width
  localparam int DLW  = 27;  // signed axis delta width
  localparam int MGW  = 26;  // delta magnitude width
  localparam int PW   = 52;  // square width
  localparam int SW   = 54;  // sum of squares width
  localparam int RTW  = 27;  // root width
  localparam int DVW  = 26;  // divisor width
  localparam int MOLN = 9;   // molecule size register width

  localparam logic [CW-1:0] MAX_DIST_RST = 24'd78643;
  localparam logic [CW-1:0] BIN_STEP_RST = 24'd655;
  localparam logic [31:0]   SAT32        = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    CMD_LOAD_RING = 3'd0,
    CMD_LOAD_ION  = 3'd1,
    CMD_EVAL      = 3'd2,
    CMD_READ      = 3'd3,
    CMD_CLEAR     = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    REG_MAX_DIST = 3'd0,
    REG_BIN_STEP = 3'd1,
    REG_INTER    = 3'd2,
    REG_INTRA    = 3'd3,
    REG_RPM      = 3'd4,
    REG_IPM      = 3'd5
  } reg_e;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_LIM,
    ST_LIMW,
    ST_PAIR,
    ST_RD1,
    ST_RD2,
    ST_RD3,
    ST_SQ0,
    ST_SQ1,
    ST_SQ2,
    ST_SQ3,
    ST_CMP,
    ST_SQRT,
    ST_DIV,
    ST_HWR,
    ST_FIN
  } state_e;

endpackage

// File: hw/rtl/rid_ram.sv
// ----------------------------------------------------------------------------
// rid_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module rid_ram #(
  parameter int W = 32,
  parameter int D = 128,
  localparam int AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [W-1:0]  wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [W-1:0]  rdata_o
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/rid_isqrt.sv
// ----------------------------------------------------------------------------
// rid_isqrt
// Iterative integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module rid_isqrt #(
  parameter int RW = 27
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [2*RW-1:0] radicand_i,
  output logic            done_o,
  output logic [RW-1:0]   root_o
);

  localparam int CNW = $clog2(RW + 1);

  logic [2*RW-1:0] rad_q, rad_d;
  logic [RW-1:0]   rem_q, rem_d;
  logic [RW-1:0]   root_q, root_d;
  logic [CNW-1:0]  cnt_q, cnt_d;
  logic            done_q, done_d;
  logic [RW+1:0]   rem_sh, trial, rem_sub;

  always_comb begin
    rem_sh  = {rem_q, rad_q[2*RW-1 -: 2]};
    trial   = {root_q, 2'b01};
    rem_sub = rem_sh - trial;
    rad_d   = rad_q;
    rem_d   = rem_q;
    root_d  = root_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    if (start_i) begin
      rad_d  = radicand_i;
      rem_d  = '0;
      root_d = '0;
      cnt_d  = CNW'(RW);
    end else if (cnt_q != '0) begin
      rad_d = rad_q << 2;
      cnt_d = cnt_q - 1'b1;
      if (rem_sh >= trial) begin
        rem_d  = rem_sub[RW-1:0];
        root_d = {root_q[RW-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh[RW-1:0];
        root_d = {root_q[RW-2:0], 1'b0};
      end
      done_d = (cnt_q == CNW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

// File: hw/rtl/rid_div.sv
// ----------------------------------------------------------------------------
// rid_div
// Iterative restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rid_div #(
  parameter int DW = 27,
  parameter int VW = 26
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic          done_o,
  output logic [DW-1:0] quot_o
);

  localparam int CNW = $clog2(DW + 1);

  logic [DW-1:0]  dvd_q, dvd_d;
  logic [DW-1:0]  quo_q, quo_d;
  logic [VW-1:0]  rem_q, rem_d;
  logic [VW-1:0]  dvs_q, dvs_d;
  logic [CNW-1:0] cnt_q, cnt_d;
  logic           done_q, done_d;
  logic [VW:0]    rem_sh, rem_sub;

  always_comb begin
    rem_sh  = {rem_q, dvd_q[DW-1]};
    rem_sub = rem_sh - {1'b0, dvs_q};
    dvd_d   = dvd_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    if (start_i) begin
      dvd_d = dividend_i;
      dvs_d = divisor_i;
      rem_d = '0;
      quo_d = '0;
      cnt_d = CNW'(DW);
    end else if (cnt_q != '0) begin
      dvd_d = dvd_q << 1;
      cnt_d = cnt_q - 1'b1;
      if (rem_sh >= {1'b0, dvs_q}) begin
        rem_d = rem_sub[VW-1:0];
        quo_d = {quo_q[DW-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[VW-1:0];
        quo_d = {quo_q[DW-2:0], 1'b0};
      end
      done_d = (cnt_q == CNW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

// File: hw/rtl/ring_ion_distance_histogram_unit.sv
// ----------------------------------------------------------------------------
// ring_ion_distance_histogram_unit
// Ring centroid to ion distance histogram with load, evaluate, read, clear.
// ----------------------------------------------------------------------------
// loads are written when accepted; a bin read strobes the registered RAM result
// clear and the pass after reset zero all NUM_BINS bins, busy meanwhile
// evaluate pairs every ion with every complete ring, skipping filtered pairs;
//   each counted pair passes the shared square root and divider in turn
// results cannot be stalled; reset restores register defaults and clears counts
module ring_ion_distance_histogram_unit #(
  parameter int MAX_RINGS = rid_pkg::MAX_RINGS_DEF,
  parameter int MAX_IONS  = rid_pkg::MAX_IONS_DEF,
  parameter int NUM_BINS  = rid_pkg::NUM_BINS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [4:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  input  logic                   start,
  output logic                   busy,
  input  logic [2:0]             command_i,
  input  logic [rid_pkg::CW-1:0] coord_x_i,
  input  logic [rid_pkg::CW-1:0] coord_y_i,
  input  logic [rid_pkg::CW-1:0] coord_z_i,
  input  logic [6:0]             bin_select_i,
  output logic                   result_valid_o,
  output logic [6:0]             bin_number_o,
  output logic [31:0]            bin_total_o,
  output logic [31:0]            frames_done_o
);

  import rid_pkg::*;

  localparam int RING_DEPTH = 3 * MAX_RINGS;
  localparam int RCW = $clog2(RING_DEPTH + 1);
  localparam int RAW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int ICW = $clog2(MAX_IONS + 1);
  localparam int IAW = (MAX_IONS > 1) ? $clog2(MAX_IONS) : 1;
  localparam int HAW = $clog2(NUM_BINS);
  localparam int MOLW = $clog2(((MAX_RINGS > MAX_IONS) ? MAX_RINGS : MAX_IONS) + 1);

  state_e state_q, state_d;

  // configuration
  logic [CW-1:0]   max_dist_q, bin_step_q;
  logic            inter_q, intra_q;
  logic [MOLN-1:0] rpm_q, ipm_q;
  logic            cfg_we;
  logic [2:0]      cfg_idx;

  // counters
  logic [RCW-1:0]  ring_cnt_q;
  logic [ICW-1:0]  ion_cnt_q;
  logic [31:0]     frame_q;
  logic [HAW-1:0]  clr_q;
  logic [ICW-1:0]  ion_idx_q;
  logic [RCW-1:0]  atom_q;
  logic [MOLN-1:0] rcnt_q, icnt_q;
  logic [MOLW-1:0] rmol_q, imol_q;
  logic [HAW:0]    active_q;

  // datapath
  logic signed [DLW-1:0] acc_q [3];
  logic [PW-1:0]   prod_q, lim2_q;
  logic [SW-1:0]   s_q;
  logic [HAW-1:0]  bin_q;
  logic [6:0]      sel_q;
  logic            range_q;

  logic            accept, ion_end, ring_end, same, skip, over;
  logic            adv_ring, next_ion;
  logic [CW-1:0]   step_eff;
  logic [MOLN-1:0] rpm_last, ipm_last;
  logic [MGW-1:0]  lim, mul_in;
  logic [MGW-1:0]  mag [3];
  logic [DVW-1:0]  step3;
  logic [RCW:0]    atom_nx;
  logic [1:0]      mul_sel, rd_off;

  logic            ring_we, ion_we, hist_we;
  logic [RAW-1:0]  ring_raddr;
  logic [3*CW-1:0] ring_rd, ion_rd, load_data;
  logic [HAW-1:0]  hist_waddr, hist_raddr, sel_addr;
  logic [31:0]     hist_wdata, hist_rd, sel_ext;

  logic            div_start, div_done, sqrt_start, sqrt_done;
  logic [RTW-1:0]  div_dvd, div_quo, root;
  logic [DVW-1:0]  div_dvs;
  logic [HAW:0]    active_n;
  logic [HAW-1:0]  bin_n;

  assign accept   = start && !busy;
  assign step_eff = (bin_step_q == '0) ? CW'(1) : bin_step_q;
  assign rpm_last = ((rpm_q == '0) ? MOLN'(1) : rpm_q) - 1'b1;
  assign ipm_last = ((ipm_q == '0) ? MOLN'(1) : ipm_q) - 1'b1;
  assign lim      = {max_dist_q, 1'b0} + {2'b00, max_dist_q};
  assign step3    = {step_eff, 1'b0} + {2'b00, step_eff};
  assign atom_nx  = {1'b0, atom_q} + (RCW+1)'(3);
  assign ion_end  = ion_idx_q >= ion_cnt_q;
  assign ring_end = atom_nx > {1'b0, ring_cnt_q};
  assign same     = rmol_q == imol_q;
  assign skip     = (inter_q && same) || (intra_q && !same);
  assign over     = s_q > {2'b00, lim2_q};
  assign load_data = {coord_z_i, coord_y_i, coord_x_i};
  assign sel_ext  = {25'd0, bin_select_i};
  assign sel_addr = sel_ext[HAW-1:0];

  assign active_n = (div_quo >= RTW'(NUM_BINS)) ? (HAW+1)'(NUM_BINS) : div_quo[HAW:0];
  assign bin_n    = (div_quo >= RTW'(active_q)) ? active_q[HAW-1:0] - 1'b1
                                                : div_quo[HAW-1:0];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mag[k] = acc_q[k][DLW-1] ? MGW'(-acc_q[k]) : MGW'(acc_q[k]);
    end
  end

  // configuration port
  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];
  assign cfg_we  = psel && penable && pwrite;

  always_comb begin
    case (cfg_idx)
      REG_MAX_DIST: prdata = {8'd0, max_dist_q};
      REG_BIN_STEP: prdata = {8'd0, bin_step_q};
      REG_INTER:    prdata = {31'd0, inter_q};
      REG_INTRA:    prdata = {31'd0, intra_q};
      REG_RPM:      prdata = {23'd0, rpm_q};
      REG_IPM:      prdata = {23'd0, ipm_q};
      default:      prdata = '0;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_q == HAW'(NUM_BINS - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          case (command_i)
            CMD_EVAL:  state_d = ST_LIM;
            CMD_READ:  state_d = ST_READ;
            CMD_CLEAR: state_d = ST_CLEAR;
            default:   state_d = ST_IDLE;
          endcase
        end
      end
      ST_READ: state_d = ST_IDLE;
      ST_LIM:  state_d = ST_LIMW;
      ST_LIMW: begin
        if (div_done) state_d = (active_n == '0) ? ST_FIN : ST_PAIR;
      end
      ST_PAIR: begin
        if (ion_end) begin
          state_d = ST_FIN;
        end else if (!ring_end && !skip) begin
          state_d = ST_RD1;
        end
      end
      ST_RD1: state_d = ST_RD2;
      ST_RD2: state_d = ST_RD3;
      ST_RD3: state_d = ST_SQ0;
      ST_SQ0: state_d = ST_SQ1;
      ST_SQ1: state_d = ST_SQ2;
      ST_SQ2: state_d = ST_SQ3;
      ST_SQ3: state_d = ST_CMP;
      ST_CMP: state_d = over ? ST_PAIR : ST_SQRT;
      ST_SQRT: begin
        if (sqrt_done) state_d = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) state_d = ST_HWR;
      end
      ST_HWR:  state_d = ST_PAIR;
      ST_FIN:  state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    busy           = state_q != ST_IDLE;
    result_valid_o = state_q == ST_READ;
    ring_we        = accept && (command_i == CMD_LOAD_RING) && (ring_cnt_q < RCW'(RING_DEPTH));
    ion_we         = accept && (command_i == CMD_LOAD_ION) && (ion_cnt_q < ICW'(MAX_IONS));
    div_start      = (state_q == ST_LIM) || ((state_q == ST_SQRT) && sqrt_done);
    div_dvd        = (state_q == ST_LIM) ? RTW'(max_dist_q) : root;
    div_dvs        = (state_q == ST_LIM) ? DVW'(step_eff) : step3;
    sqrt_start     = (state_q == ST_CMP) && !over;
    next_ion       = (state_q == ST_PAIR) && !ion_end && ring_end;
    adv_ring       = ((state_q == ST_PAIR) && !ion_end && !ring_end && skip) ||
                     ((state_q == ST_CMP) && over) || (state_q == ST_HWR);
    hist_we        = (state_q == ST_CLEAR) || (state_q == ST_HWR);
    hist_waddr     = (state_q == ST_CLEAR) ? clr_q : bin_q;
    hist_wdata     = (state_q == ST_CLEAR) ? '0 :
                     (hist_rd == SAT32) ? SAT32 : hist_rd + 1'b1;
    hist_raddr     = (state_q == ST_DIV) ? bin_n : sel_addr;
    case (state_q)
      ST_RD1:  rd_off = 2'd1;
      ST_RD2:  rd_off = 2'd2;
      default: rd_off = 2'd0;
    endcase
    case (state_q)
      ST_SQ0:  mul_sel = 2'd0;
      ST_SQ1:  mul_sel = 2'd1;
      ST_SQ2:  mul_sel = 2'd2;
      default: mul_sel = 2'd3;
    endcase
  end

  always_comb begin
    logic [RCW:0] ra;
    ra         = {1'b0, atom_q} + (RCW+1)'(rd_off);
    ring_raddr = ra[RAW-1:0];
    case (mul_sel)
      2'd0:    mul_in = mag[0];
      2'd1:    mul_in = mag[1];
      2'd2:    mul_in = mag[2];
      default: mul_in = lim;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      max_dist_q <= MAX_DIST_RST;
      bin_step_q <= BIN_STEP_RST;
      inter_q    <= 1'b0;
      intra_q    <= 1'b0;
      rpm_q      <= MOLN'(1);
      ipm_q      <= MOLN'(1);
      ring_cnt_q <= '0;
      ion_cnt_q  <= '0;
      frame_q    <= '0;
      clr_q      <= '0;
      ion_idx_q  <= '0;
      atom_q     <= '0;
      rcnt_q     <= '0;
      icnt_q     <= '0;
      rmol_q     <= '0;
      imol_q     <= '0;
      active_q   <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we) begin
        case (cfg_idx)
          REG_MAX_DIST: max_dist_q <= pwdata[CW-1:0];
          REG_BIN_STEP: bin_step_q <= pwdata[CW-1:0];
          REG_INTER:    inter_q    <= pwdata[0];
          REG_INTRA:    intra_q    <= pwdata[0];
          REG_RPM:      rpm_q      <= pwdata[MOLN-1:0];
          REG_IPM:      ipm_q      <= pwdata[MOLN-1:0];
          default:      ;
        endcase
      end
      if (ring_we) ring_cnt_q <= ring_cnt_q + 1'b1;
      if (ion_we) ion_cnt_q <= ion_cnt_q + 1'b1;
      if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
      if (accept && (command_i == CMD_CLEAR)) begin
        clr_q   <= '0;
        frame_q <= '0;
      end
      if ((state_q == ST_LIMW) && div_done) begin
        active_q  <= active_n;
        ion_idx_q <= '0;
        atom_q    <= '0;
        rcnt_q    <= '0;
        rmol_q    <= '0;
        icnt_q    <= '0;
        imol_q    <= '0;
      end
      if (adv_ring) begin
        atom_q <= atom_nx[RCW-1:0];
        if (rcnt_q == rpm_last) begin
          rcnt_q <= '0;
          rmol_q <= rmol_q + 1'b1;
        end else begin
          rcnt_q <= rcnt_q + 1'b1;
        end
      end
      if (next_ion) begin
        ion_idx_q <= ion_idx_q + 1'b1;
        atom_q    <= '0;
        rcnt_q    <= '0;
        rmol_q    <= '0;
        if (icnt_q == ipm_last) begin
          icnt_q <= '0;
          imol_q <= imol_q + 1'b1;
        end else begin
          icnt_q <= icnt_q + 1'b1;
        end
      end
      if (state_q == ST_FIN) begin
        if (frame_q != SAT32) frame_q <= frame_q + 1'b1;
        ring_cnt_q <= '0;
        ion_cnt_q  <= '0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    prod_q <= mul_in * mul_in;
    if (state_q == ST_LIMW) lim2_q <= prod_q;
    for (int k = 0; k < 3; k++) begin
      if (state_q == ST_RD1) begin
        acc_q[k] <= DLW'($signed(ring_rd[k*CW +: CW]))
                  - DLW'($signed({ion_rd[k*CW +: CW], 1'b0}))
                  - DLW'($signed(ion_rd[k*CW +: CW]));
      end else if ((state_q == ST_RD2) || (state_q == ST_RD3)) begin
        acc_q[k] <= acc_q[k] + DLW'($signed(ring_rd[k*CW +: CW]));
      end
    end
    if (state_q == ST_SQ1) s_q <= {2'b00, prod_q};
    if ((state_q == ST_SQ2) || (state_q == ST_SQ3)) s_q <= s_q + {2'b00, prod_q};
    if ((state_q == ST_DIV) && div_done) bin_q <= bin_n;
    if (accept && (command_i == CMD_READ)) begin
      sel_q   <= bin_select_i;
      range_q <= sel_ext < 32'(NUM_BINS);
    end
  end

  assign bin_number_o  = sel_q;
  assign bin_total_o   = range_q ? hist_rd : '0;
  assign frames_done_o = frame_q;

  rid_ram #(.W(3*CW), .D(RING_DEPTH)) u_ring_ram (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (ring_cnt_q[RAW-1:0]),
    .wdata_i (load_data),
    .raddr_i (ring_raddr),
    .rdata_o (ring_rd)
  );

  rid_ram #(.W(3*CW), .D(MAX_IONS)) u_ion_ram (
    .clk_i   (clk_i),
    .we_i    (ion_we),
    .waddr_i (ion_cnt_q[IAW-1:0]),
    .wdata_i (load_data),
    .raddr_i (ion_idx_q[IAW-1:0]),
    .rdata_o (ion_rd)
  );

  rid_ram #(.W(32), .D(NUM_BINS)) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i (hist_waddr),
    .wdata_i (hist_wdata),
    .raddr_i (hist_raddr),
    .rdata_o (hist_rd)
  );

  rid_isqrt #(.RW(RTW)) u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sqrt_start),
    .radicand_i (s_q),
    .done_o     (sqrt_done),
    .root_o     (root)
  );

  rid_div #(.DW(RTW), .VW(DVW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quot_o     (div_quo)
  );

  a_result_from_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start && !busy && (command_i == CMD_READ)))
    else $error("result strobe without a read transfer");

  a_bin_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_HWR) |-> ({1'b0, bin_q} < active_q))
    else $error("histogram update outside active bins");

  a_load_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ring_cnt_q <= RCW'(RING_DEPTH)) && (ion_cnt_q <= ICW'(MAX_IONS)))
    else $error("load count past store depth");

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the ring-ion distance histogram unit: directed
// frames cover filters, bin clamping, store limits and clears, then random
// frames under random configurations; every bin read is checked in order.
// ----------------------------------------------------------------------------
module tb;
  import rid_pkg::*;

  localparam int N_RING_ATOMS = 3 * MAX_RINGS_DEF;
  localparam int N_IONS       = MAX_IONS_DEF;
  localparam int N_BINS       = NUM_BINS_DEF;
  localparam logic [2:0] CMD_SPARE_LO = 3'd5;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [6:0]  bin;
    logic [31:0] total;
    logic [31:0] frames;
  } bin_report_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  command_i = CMD_CLEAR;
  logic [CW-1:0] coord_x_i = '0, coord_y_i = '0, coord_z_i = '0;
  logic [6:0]  bin_select_i = '0;
  logic        result_valid_o;
  logic [6:0]  bin_number_o;
  logic [31:0] bin_total_o;
  logic [31:0] frames_done_o;

  ring_ion_distance_histogram_unit i_dut (.*);

  always #1 clk_i = ~clk_i;

  // predictor state
  logic [CW-1:0] ring_x [N_RING_ATOMS];
  logic [CW-1:0] ring_y [N_RING_ATOMS];
  logic [CW-1:0] ring_z [N_RING_ATOMS];
  logic [CW-1:0] ion_x [N_IONS];
  logic [CW-1:0] ion_y [N_IONS];
  logic [CW-1:0] ion_z [N_IONS];
  logic [31:0]   hist [N_BINS];
  int unsigned   atoms_in, ions_in;
  logic [31:0]   frame_cnt;
  logic [23:0]   cfg_max, cfg_step;
  logic          cfg_inter, cfg_intra;
  logic [8:0]    cfg_rpm, cfg_ipm;

  bin_report_t pending_reports[$];
  int unsigned errors = 0, reads_seen = 0, frames_run = 0, counted_pairs = 0;
  int unsigned items_sent = 0;
  bit          gaps_on = 1'b1;

  function automatic longint sx(logic [CW-1:0] v);
    return longint'($signed(v));
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned s);
    longint unsigned root = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > s) b >>= 2;
    while (b != 0) begin
      if (s >= root + b) begin
        s -= root + b;
        root = (root >> 1) + b;
      end else begin
        root >>= 1;
      end
      b >>= 2;
    end
    return root;
  endfunction

  function automatic void tally_frame();
    longint unsigned step, rpm, ipm, active, lim, lim2, dv, s, bin;
    longint dx, dy, dz;
    int unsigned rings;
    bit same;
    step = (cfg_step == 0) ? 1 : cfg_step;
    rpm = (cfg_rpm == 0) ? 1 : cfg_rpm;
    ipm = (cfg_ipm == 0) ? 1 : cfg_ipm;
    active = cfg_max / step;
    if (active > N_BINS) active = N_BINS;
    lim = 3 * longint'(cfg_max);
    lim2 = lim * lim;
    dv = 3 * step;
    rings = atoms_in / 3;
    for (int i = 0; i < ions_in; i++) begin
      for (int r = 0; r < rings; r++) begin
        same = (r / rpm) == (i / ipm);
        if ((cfg_inter && same) || (cfg_intra && !same) || active == 0) continue;
        dx = sx(ring_x[3*r]) + sx(ring_x[3*r+1]) + sx(ring_x[3*r+2]) - 3 * sx(ion_x[i]);
        dy = sx(ring_y[3*r]) + sx(ring_y[3*r+1]) + sx(ring_y[3*r+2]) - 3 * sx(ion_y[i]);
        dz = sx(ring_z[3*r]) + sx(ring_z[3*r+1]) + sx(ring_z[3*r+2]) - 3 * sx(ion_z[i]);
        s = dx * dx + dy * dy + dz * dz;
        if (s > lim2) continue;
        bin = int_sqrt(s) / dv;
        if (bin >= active) bin = active - 1;
        if (hist[bin] != SAT32) hist[bin]++;
        counted_pairs++;
      end
    end
    if (frame_cnt != SAT32) frame_cnt++;
    atoms_in = 0;
    ions_in = 0;
    frames_run++;
  endfunction

  function automatic void apply_command(logic [2:0] cmd, logic [CW-1:0] x, logic [CW-1:0] y,
                                        logic [CW-1:0] z, logic [6:0] sel);
    bin_report_t rep;
    case (cmd)
      CMD_LOAD_RING: begin
        if (atoms_in < N_RING_ATOMS) begin
          ring_x[atoms_in] = x;
          ring_y[atoms_in] = y;
          ring_z[atoms_in] = z;
          atoms_in++;
        end
      end
      CMD_LOAD_ION: begin
        if (ions_in < N_IONS) begin
          ion_x[ions_in] = x;
          ion_y[ions_in] = y;
          ion_z[ions_in] = z;
          ions_in++;
        end
      end
      CMD_EVAL: tally_frame();
      CMD_READ: begin
        rep.bin = sel;
        rep.total = (sel < N_BINS) ? hist[sel] : 32'd0;
        rep.frames = frame_cnt;
        pending_reports.push_back(rep);
      end
      CMD_CLEAR: begin
        foreach (hist[k]) hist[k] = '0;
        frame_cnt = '0;
      end
      default: ;
    endcase
  endfunction

  // one transfer; called at a rising edge, returns at the accepting edge
  task automatic send(logic [2:0] cmd, logic [CW-1:0] x = '0, logic [CW-1:0] y = '0,
                      logic [CW-1:0] z = '0, logic [6:0] sel = '0);
    start <= 1'b1;
    command_i <= cmd;
    coord_x_i <= x;
    coord_y_i <= y;
    coord_z_i <= z;
    bin_select_i <= sel;
    do @(posedge clk_i); while (busy);
    apply_command(cmd, x, y, z, sel);
    items_sent++;
  endtask

  task automatic pause(int unsigned n);
    if (n != 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic random_gap();
    int unsigned p;
    p = $urandom_range(99);
    if (!gaps_on || p < 65) return;
    if (p < 95) pause($urandom_range(3, 1));
    else pause($urandom_range(40, 10));
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk_i); while (busy || pending_reports.size() != 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic reg_write(reg_e idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 5'(idx) << 2;
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_MAX_DIST: cfg_max = val[23:0];
      REG_BIN_STEP: cfg_step = val[23:0];
      REG_INTER:    cfg_inter = val[0];
      REG_INTRA:    cfg_intra = val[0];
      REG_RPM:      cfg_rpm = val[8:0];
      REG_IPM:      cfg_ipm = val[8:0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [23:0] mx, logic [23:0] st, bit inter, bit intra,
                            logic [8:0] rpm, logic [8:0] ipm);
    drain();
    reg_write(REG_MAX_DIST, 32'(mx));
    reg_write(REG_BIN_STEP, 32'(st));
    reg_write(REG_INTER, 32'(inter));
    reg_write(REG_INTRA, 32'(intra));
    reg_write(REG_RPM, 32'(rpm));
    reg_write(REG_IPM, 32'(ipm));
  endtask

  task automatic ring_at(logic [CW-1:0] x, logic [CW-1:0] y, logic [CW-1:0] z);
    repeat (3) send(CMD_LOAD_RING, x, y, z);
  endtask

  task automatic read_bins(int unsigned lo, int unsigned hi);
    for (int unsigned b = lo; b <= hi; b++) send(CMD_READ, '0, '0, '0, 7'(b));
  endtask

  task automatic test_extremes();
    send(CMD_READ, '0, '0, '0, 7'd127);
    send(CMD_LOAD_RING, 24'h7FFFFF, 24'h800000, 24'h7FFFFF);
    send(CMD_LOAD_RING, 24'h800000, 24'h7FFFFF, 24'h800000);
    send(CMD_LOAD_RING, 24'h000000, 24'hFFFFFF, 24'h000001);
    send(CMD_LOAD_ION, 24'h000000, 24'h000000, 24'h000000);
    send(CMD_LOAD_ION, 24'h000100, 24'hFFFF00, 24'h000200);
    send(CMD_LOAD_RING, 24'h1, 24'h1, 24'h1);  // incomplete ring
    send(CMD_EVAL);
    read_bins(0, 2);
    send(CMD_SPARE_LO);
    send(CMD_SPARE_HI, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 7'h7F);
    send(CMD_EVAL);  // empty frame
    send(CMD_READ, '0, '0, '0, 7'd0);
  endtask

  task automatic test_clamp();
    // maximum is exactly four steps: a pair at the maximum lands in bin 3
    set_config(24'd2620, 24'd655, 1'b0, 1'b0, 9'd1, 9'd1);
    ring_at(24'd0, 24'd0, 24'd0);
    send(CMD_LOAD_ION, 24'd2620, 24'd0, 24'd0);
    send(CMD_LOAD_ION, 24'd2621, 24'd0, 24'd0);
    send(CMD_LOAD_ION, 24'd700, 24'd0, 24'd0);
    send(CMD_EVAL);
    read_bins(0, 4);
    // maximum below the step: nothing counted
    set_config(24'd100, 24'd655, 1'b0, 1'b0, 9'd1, 9'd1);
    ring_at(24'd0, 24'd0, 24'd0);
    send(CMD_LOAD_ION, 24'd0, 24'd0, 24'd0);
    send(CMD_EVAL);
    send(CMD_READ);
    // zero step, huge maximum: the far pair is beyond the limit, the near one counts in bin 0
    set_config(24'hFFFFFF, 24'd0, 1'b0, 1'b0, 9'd0, 9'd0);
    ring_at(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
    send(CMD_LOAD_ION, 24'h800000, 24'h800000, 24'h800000);
    send(CMD_LOAD_ION, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
    send(CMD_EVAL);
    send(CMD_READ, '0, '0, '0, 7'd127);
    send(CMD_READ, '0, '0, '0, 7'd0);
    send(CMD_CLEAR);
    send(CMD_READ, '0, '0, '0, 7'd127);
  endtask

  task automatic test_filters();
    for (int mode = 0; mode < 4; mode++) begin
      set_config(24'd78643, 24'd655, mode[0], mode[1], 9'd2, (mode == 3) ? 9'd511 : 9'd1);
      for (int r = 0; r < 4; r++) ring_at(24'(r * 40), 24'd0, 24'd0);
      for (int i = 0; i < 3; i++) send(CMD_LOAD_ION, 24'(i * 700), 24'd0, 24'd0);
      send(CMD_EVAL);
      read_bins(0, 2);
    end
  endtask

  // both stores overflow in one frame
  task automatic test_store_full();
    set_config(24'd78643, 24'd655, 1'b0, 1'b0, 9'd1, 9'd1);
    send(CMD_CLEAR);
    for (int a = 0; a < N_RING_ATOMS + 2; a++)
      send(CMD_LOAD_RING, 24'($urandom_range(600)), 24'($urandom_range(600)), 24'(a));
    for (int i = 0; i < N_IONS + 2; i++)
      send(CMD_LOAD_ION, 24'(i * 4000), 24'($urandom_range(1000)), 24'd0);
    send(CMD_EVAL);
    read_bins(0, 3);
    read_bins(100, 103);
  endtask

  task automatic random_config();
    logic [23:0] mx, st;
    case ($urandom_range(5))
      0: mx = 24'd0;
      1: mx = 24'hFFFFFF;
      default: mx = 24'($urandom_range(200000, 500));
    endcase
    case ($urandom_range(5))
      0: st = 24'd0;
      1: st = 24'hFFFFFF;
      2: st = 24'd1;
      default: st = 24'(($urandom_range(mx) / 128) + 1 + $urandom_range(3000));
    endcase
    set_config(mx, st, $urandom_range(3) == 0, $urandom_range(3) == 0,
               9'($urandom_range(511) % ($urandom_range(1) ? 4 : 512)),
               9'($urandom_range(511) % ($urandom_range(1) ? 4 : 512)));
  endtask

  task automatic test_random(int unsigned target);
    int unsigned nfr, scale, n;
    logic [CW-1:0] cx, cy, cz;
    nfr = 0;
    while (items_sent < target) begin
      if (nfr % 8 == 0) random_config();
      if (nfr == 30) drain();  // full quiet point with no transfer pending
      gaps_on = $urandom_range(3) != 0;
      nfr++;
      scale = (cfg_max == 0) ? 1000 : ((cfg_max > 24'h100000) ? 24'h100000 : cfg_max);
      cx = 24'($urandom);
      cy = 24'($urandom);
      cz = 24'($urandom);
      n = $urandom_range(20);
      for (int k = 0; k < n; k++) begin
        if ($urandom_range(9) == 0)
          send(CMD_LOAD_RING, 24'($urandom), 24'($urandom), 24'($urandom));
        else
          send(CMD_LOAD_RING, cx + 24'($urandom_range(2 * scale) - scale),
               cy + 24'($urandom_range(scale / 4)), cz - 24'($urandom_range(scale / 4)));
        random_gap();
      end
      n = $urandom_range(7);
      for (int k = 0; k < n; k++) begin
        if ($urandom_range(9) == 0)
          send(CMD_LOAD_ION, 24'($urandom), 24'($urandom), 24'($urandom));
        else
          send(CMD_LOAD_ION, cx + 24'($urandom_range(2 * scale) - scale),
               cy - 24'($urandom_range(scale / 2)), cz + 24'($urandom_range(scale / 2)));
        random_gap();
      end
      case ($urandom_range(19))
        0: send(CMD_CLEAR);
        1: send(3'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO)), 24'($urandom),
                24'($urandom), 24'($urandom), 7'($urandom));
        default: ;
      endcase
      if ($urandom_range(9) != 0) send(CMD_EVAL);
      random_gap();
      n = $urandom_range(4, 1);
      for (int k = 0; k < n; k++) begin
        send(CMD_READ, '0, '0, '0, ($urandom_range(1) ? 7'($urandom_range(7)) : 7'($urandom)));
        random_gap();
      end
    end
  endtask

  // result checker
  always @(posedge clk_i) begin
    bin_report_t exp_rep;
    if (rst_ni && result_valid_o) begin
      reads_seen++;
      if (pending_reports.size() == 0) begin
        errors++;
        $display("%0t: unexpected bin report bin=%0d total=%0d frames=%0d", $time,
                 bin_number_o, bin_total_o, frames_done_o);
      end else begin
        exp_rep = pending_reports.pop_front();
        if (bin_number_o !== exp_rep.bin) begin
          errors++;
          $display("%0t: bin_number expected %0d actual %0d", $time, exp_rep.bin,
                   bin_number_o);
        end
        if (bin_total_o !== exp_rep.total) begin
          errors++;
          $display("%0t: bin_total (bin %0d) expected %0d actual %0d", $time, exp_rep.bin,
                   exp_rep.total, bin_total_o);
        end
        if (frames_done_o !== exp_rep.frames) begin
          errors++;
          $display("%0t: frames_done expected %0d actual %0d", $time, exp_rep.frames,
                   frames_done_o);
        end
      end
    end
  end

  initial begin
    #100_000_000;
    $display("ring_ion_distance_histogram_unit: mismatch");
    $finish;
  end

  initial begin
    foreach (hist[k]) hist[k] = '0;
    atoms_in = 0;
    ions_in = 0;
    frame_cnt = '0;
    cfg_max = MAX_DIST_RST;
    cfg_step = BIN_STEP_RST;
    cfg_inter = 1'b0;
    cfg_intra = 1'b0;
    cfg_rpm = 9'd1;
    cfg_ipm = 9'd1;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_clamp();
    test_filters();
    test_store_full();
    test_random(items_sent + 20);
    drain();
    if (pending_reports.size() != 0) errors++;
    $display("ran %0d transfers over %0d frames, %0d pairs counted, %0d bin reads checked",
             items_sent, frames_run, counted_pairs, reads_seen);
    if (errors == 0) begin
      $display("ring_ion_distance_histogram_unit: match");
    end else begin
      $display("ring_ion_distance_histogram_unit: mismatch");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/rid_pkg.sv
hw/rtl/rid_ram.sv
hw/rtl/rid_isqrt.sv
hw/rtl/rid_div.sv
hw/rtl/ring_ion_distance_histogram_unit.sv
test/tb.sv
